// ===== rtl/ts_pid_payload_extractor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor_unit_defines.svh
// Assertion macros shared by the checker of the transport stream extractor.
// ----------------------------------------------------------------------------
`ifndef TS_PID_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH
`define TS_PID_PAYLOAD_EXTRACTOR_UNIT_DEFINES_SVH

// Payload of a stalled beat must hold until the beat is taken.
`define TSPE_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        ((vld) && !(rdy)) |=> $stable(sig)) \
        else $error("stalled beat payload changed");

// Same-cycle implication checked on every clock edge out of reset.
`define TSPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) \
        else $error("result beat field rule violated");

`endif

// ===== rtl/tspe_pkg.sv =====
// ----------------------------------------------------------------------------
// tspe_pkg
// Types and constants of the transport stream PID filter and payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tspe_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'h47;
    localparam logic [7:0]  PKT_LEN        = 8'd188;
    localparam logic [7:0]  LAST_POS       = 8'd187;
    localparam logic [7:0]  HDR_LAST_POS   = 8'd3;
    localparam logic [12:0] NULL_PID       = 13'h1FFF;
    localparam logic [12:0] TARGET_RESET   = 13'h1000;
    localparam logic [8:0]  MAX_ADAPT_LEN  = 9'd183;
    localparam logic [1:0]  AFC_ADAPT_ONLY = 2'b10;
    localparam logic [1:0]  AFC_BOTH       = 2'b11;

    // APB register map: one register, word-addressed by paddr[2]
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_TARGET_PID = 1'b0;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_BODY   = 2'd2,
        MODE_DROP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_CC_ERR    = 3'd1,
        EV_TEI       = 3'd2,
        EV_SCRAMBLED = 3'd3,
        EV_SYNC_LOSS = 3'd4,
        EV_BAD_AF    = 3'd5,
        EV_BAD_PTR   = 3'd6
    } t_event;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       seek_unit_start;
    } t_in_beat;

    typedef struct packed {
        t_event     event_kind;
        logic [7:0] payload_byte;
        logic       unit_start;
        logic [3:0] expected_count;
        logic [3:0] found_count;
    } t_out_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_step_res;

endpackage

`default_nettype wire

// ===== rtl/tspe_cfg.sv =====
// ----------------------------------------------------------------------------
// tspe_cfg
// APB register file holding the target PID.
// ----------------------------------------------------------------------------
`default_nettype none

module tspe_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tspe_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output logic      [12:0]                     o_target_pid
);
    import tspe_pkg::*;

    logic [12:0] r_target_pid;
    logic        w_sel_target;

    assign w_sel_target = (paddr[CFG_ADDR_W-1] == REG_TARGET_PID);
    assign pready       = 1'b1;
    assign o_target_pid = r_target_pid;

    always_comb begin
        prdata = '0;
        if (w_sel_target) begin
            prdata = {19'd0, r_target_pid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid <= TARGET_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_target) begin
            r_target_pid <= pwdata[12:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tspe_step.sv =====
// ----------------------------------------------------------------------------
// tspe_step
// Packet state machine: sync, header checks, PID filter, continuity, adaptation
// and pointer skipping. Updates state and forms at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tspe_step (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire tspe_pkg::t_in_beat   i_beat,
    input  wire logic [12:0]          i_target_pid,
    output tspe_pkg::t_step_res       o_res
);
    import tspe_pkg::*;

    t_mode       r_mode,     n_mode;
    logic [7:0]  r_pos,      n_pos;
    logic [23:0] r_hdr,      n_hdr;
    logic [3:0]  r_cc,       n_cc;
    logic        r_cc_vld,   n_cc_vld;
    logic        r_seeking,  n_seeking;
    logic [7:0]  r_skip,     n_skip;
    logic        r_len_pend, n_len_pend;
    logic        r_ptr_last, n_ptr_last;
    logic        r_mark,     n_mark;

    logic [7:0]  w_b;
    logic        w_abort;
    t_mode       w_mode0;
    logic        w_seek0, w_mark0, w_len0, w_ptr0;
    logic [7:0]  w_skip0;
    logic [12:0] w_pid;
    logic        w_pusi, w_tei, w_scr, w_pass;
    logic [1:0]  w_afc;
    logic [3:0]  w_found, w_cc_cmp;
    logic [8:0]  w_total;
    logic        w_ptr_end, w_ptr_bad;
    logic [7:0]  w_pos_inc;

    assign w_b = i_beat.stream_byte;

    // A seek request mid-packet drops this byte and the rest of the packet
    assign w_abort = i_beat.seek_unit_start && (r_pos != 8'd0)
                     && (r_mode == MODE_HEADER || r_mode == MODE_BODY);
    assign w_mode0 = w_abort ? MODE_DROP : r_mode;
    assign w_seek0 = i_beat.seek_unit_start ? 1'b1 : r_seeking;
    assign w_mark0 = i_beat.seek_unit_start ? 1'b0 : r_mark;
    assign w_len0  = w_abort ? 1'b0 : r_len_pend;
    assign w_ptr0  = w_abort ? 1'b0 : r_ptr_last;
    assign w_skip0 = w_abort ? 8'd0 : r_skip;

    // Header fields, decoded while the fourth header byte is on the input
    assign w_tei    = r_hdr[15];
    assign w_pusi   = r_hdr[14];
    assign w_pid    = {r_hdr[12:8], r_hdr[7:0]};
    assign w_scr    = (w_b[7:6] != 2'b00);
    assign w_afc    = w_b[5:4];
    assign w_found  = w_b[3:0];
    assign w_pass   = (w_pid != NULL_PID) && (w_pid == i_target_pid)
                      && (w_afc != AFC_ADAPT_ONLY);
    assign w_cc_cmp = r_cc_vld ? r_cc : w_found;

    assign w_total   = {1'b0, w_b} + {8'd0, r_hdr[22]};
    assign w_ptr_end = (w_skip0 == 8'd1) && w_ptr0;
    assign w_ptr_bad = (w_b > (LAST_POS - r_pos));
    assign w_pos_inc = r_pos + 8'd1;

    // Next state
    always_comb begin
        n_mode     = w_mode0;
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_cc       = r_cc;
        n_cc_vld   = r_cc_vld;
        n_seeking  = w_seek0;
        n_skip     = w_skip0;
        n_len_pend = w_len0;
        n_ptr_last = w_ptr0;
        n_mark     = w_mark0;
        case (w_mode0)
            MODE_HUNT: begin
                if (w_b == SYNC_BYTE) begin
                    n_mode = MODE_HEADER;
                    n_pos  = 8'd1;
                    n_hdr  = '0;
                end
            end
            MODE_HEADER: begin
                n_pos = w_pos_inc;
                if (r_pos == 8'd0) begin
                    n_hdr = '0;
                    if (w_b != SYNC_BYTE) begin
                        // lost sync: hunt byte by byte
                        n_mode     = MODE_HUNT;
                        n_pos      = 8'd0;
                        n_seeking  = 1'b1;
                        n_mark     = 1'b0;
                        n_len_pend = 1'b0;
                        n_ptr_last = 1'b0;
                        n_skip     = 8'd0;
                    end
                end else begin
                    n_hdr = {r_hdr[15:0], w_b};
                    if (r_pos == HDR_LAST_POS) begin
                        if (w_tei || w_scr) begin
                            n_mode     = MODE_DROP;
                            n_seeking  = 1'b1;
                            n_mark     = 1'b0;
                            n_len_pend = 1'b0;
                            n_ptr_last = 1'b0;
                            n_skip     = 8'd0;
                        end else if (!w_pass) begin
                            n_mode = MODE_DROP;
                        end else begin
                            n_cc     = w_found + 4'd1;
                            n_cc_vld = 1'b1;
                            if (w_seek0 && !w_pusi) begin
                                n_mode = MODE_DROP;
                            end else begin
                                n_mode     = MODE_BODY;
                                n_len_pend = (w_afc == AFC_BOTH);
                                n_ptr_last = w_pusi && w_seek0;
                                n_skip     = ((w_afc != AFC_BOTH) && w_pusi) ? 8'd1 : 8'd0;
                            end
                        end
                    end
                end
            end
            MODE_BODY: begin
                n_pos = w_pos_inc;
                if (w_len0) begin
                    n_len_pend = 1'b0;
                    if (w_total > MAX_ADAPT_LEN) begin
                        n_mode     = MODE_DROP;
                        n_seeking  = 1'b1;
                        n_mark     = 1'b0;
                        n_ptr_last = 1'b0;
                        n_skip     = 8'd0;
                    end else begin
                        n_skip = w_total[7:0];
                    end
                end else if (w_skip0 != 8'd0) begin
                    n_skip = w_skip0 - 8'd1;
                    if (w_ptr_end) begin
                        n_ptr_last = 1'b0;
                        if (w_ptr_bad) begin
                            n_mode    = MODE_DROP;
                            n_seeking = 1'b1;
                            n_mark    = 1'b0;
                            n_skip    = 8'd0;
                        end else begin
                            n_skip    = w_b;
                            n_seeking = 1'b0;
                            n_mark    = 1'b1;
                        end
                    end
                end else begin
                    n_mark = 1'b0;
                end
            end
            MODE_DROP: begin
                n_pos = w_pos_inc;
            end
            default: begin
                n_mode = MODE_HUNT;
            end
        endcase
        // Packet boundary: expect the next sync byte
        if (w_mode0 != MODE_HUNT && n_mode != MODE_HUNT && n_pos >= PKT_LEN) begin
            n_pos      = 8'd0;
            n_mode     = MODE_HEADER;
            n_len_pend = 1'b0;
            n_ptr_last = 1'b0;
            n_skip     = 8'd0;
        end
    end

    // Result
    always_comb begin
        o_res = '0;
        if (i_en) begin
            case (w_mode0)
                MODE_HEADER: begin
                    if (r_pos == 8'd0) begin
                        if (w_b != SYNC_BYTE) begin
                            o_res.valid           = 1'b1;
                            o_res.beat.event_kind = EV_SYNC_LOSS;
                        end
                    end else if (r_pos == HDR_LAST_POS) begin
                        if (w_tei) begin
                            o_res.valid           = 1'b1;
                            o_res.beat.event_kind = EV_TEI;
                        end else if (w_scr) begin
                            o_res.valid           = 1'b1;
                            o_res.beat.event_kind = EV_SCRAMBLED;
                        end else if (w_pass && (w_cc_cmp != w_found)) begin
                            o_res.valid               = 1'b1;
                            o_res.beat.event_kind     = EV_CC_ERR;
                            o_res.beat.expected_count = w_cc_cmp;
                            o_res.beat.found_count    = w_found;
                        end
                    end
                end
                MODE_BODY: begin
                    if (w_len0) begin
                        if (w_total > MAX_ADAPT_LEN) begin
                            o_res.valid           = 1'b1;
                            o_res.beat.event_kind = EV_BAD_AF;
                        end
                    end else if (w_skip0 != 8'd0) begin
                        if (w_ptr_end && w_ptr_bad) begin
                            o_res.valid           = 1'b1;
                            o_res.beat.event_kind = EV_BAD_PTR;
                        end
                    end else begin
                        o_res.valid             = 1'b1;
                        o_res.beat.event_kind   = EV_PAYLOAD;
                        o_res.beat.payload_byte = w_b;
                        o_res.beat.unit_start   = w_mark0;
                    end
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HUNT;
            r_pos      <= 8'd0;
            r_hdr      <= '0;
            r_cc       <= 4'd0;
            r_cc_vld   <= 1'b0;
            r_seeking  <= 1'b1;
            r_skip     <= 8'd0;
            r_len_pend <= 1'b0;
            r_ptr_last <= 1'b0;
            r_mark     <= 1'b0;
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_hdr      <= n_hdr;
            r_cc       <= n_cc;
            r_cc_vld   <= n_cc_vld;
            r_seeking  <= n_seeking;
            r_skip     <= n_skip;
            r_len_pend <= n_len_pend;
            r_ptr_last <= n_ptr_last;
            r_mark     <= n_mark;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ts_pid_payload_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor_unit
// MPEG transport stream PID filter and payload extractor, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one transport stream byte per input beat and returns at most one
// result beat per byte: a payload byte of the selected PID or an error event.
// Throughput is one byte per clock while the output is not stalled; a byte
// passes an input register, the packet state logic and the result register.
// The packet state update is the step that sets this rate.
// Input ready drops only while both registers hold beats and the output stalls.
// Write target_pid over APB at byte address 0 while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_pid_payload_extractor_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire tspe_pkg::t_in_beat              i_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output tspe_pkg::t_out_beat                  o_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tspe_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import tspe_pkg::*;

    logic        r_in_valid;
    t_in_beat    r_in_beat;
    logic        r_out_valid;
    t_out_beat   r_out_beat;
    logic        w_adv;
    logic        w_out_free;
    logic [12:0] w_target_pid;
    t_step_res   w_res;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_adv;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_beat;

    tspe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_target_pid(w_target_pid)
    );

    tspe_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_beat      (r_in_beat),
        .i_target_pid(w_target_pid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_beat <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && w_res.valid;
        end
    end

    // hold the result beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_beat <= w_res.beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tspe_checker.sv =====
// ----------------------------------------------------------------------------
// tspe_checker
// Port-level checks on the result channel of the payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ts_pid_payload_extractor_unit_defines.svh"

module tspe_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire tspe_pkg::t_out_beat o_data
);
    import tspe_pkg::*;

    `TSPE_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid, i_ready, o_data)
    `TSPE_ASSERT_IMPL(a_data_only_payload, i_clk, i_rst_n, o_valid && (o_data.event_kind != EV_PAYLOAD), o_data.payload_byte == 8'd0)
    `TSPE_ASSERT_IMPL(a_mark_only_payload, i_clk, i_rst_n, o_valid && o_data.unit_start, o_data.event_kind == EV_PAYLOAD)
    `TSPE_ASSERT_IMPL(a_counts_only_cc, i_clk, i_rst_n, o_valid && (o_data.event_kind != EV_CC_ERR), (o_data.expected_count == 4'd0) && (o_data.found_count == 4'd0))

endmodule

bind ts_pid_payload_extractor_unit tspe_checker u_tspe_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transport stream PID filter and payload extractor.
// ----------------------------------------------------------------------------
// Builds 188-byte packets (unit start after a hunt, foreign PID, continuity
// error with an adaptation field, oversized adaptation field, transport error,
// pointer running to the packet end, seek partway through a packet), pushes
// them one byte per beat, and tracks every accepted byte with a local model of
// the packet state machine. Each result beat is compared field by field with
// the oldest predicted event. target_pid is rewritten over APB and read back.
// Sender gaps, receiver stalls and one long receiver hold-off exercise the
// handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tspe_pkg::*;

    localparam logic [1:0]            AFC_RESERVED   = 2'b00;
    localparam logic [1:0]            AFC_PAYLOAD    = 2'b01;
    localparam logic [CFG_ADDR_W-1:0] TPID_ADDR      = {REG_TARGET_PID, 2'b00};
    localparam int                    RX_HOLD_CYCLES = 400;
    localparam int                    SETTLE_CYCLES  = 8;
    localparam int                    REPORT_CAP     = 40;

    typedef struct {
        logic [12:0] pid;
        bit          tei;
        bit          pusi;
        logic [1:0]  scr;
        logic [1:0]  afc;
        logic [3:0]  cc;
        int          af_len;
        int          ptr;
        int          seek_at;
        bit          bad_sync;
    } ts_pkt_t;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_beat              i_data  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_beat             o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    ts_pid_payload_extractor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Extractor state as the block should hold it
    logic [12:0] tgt_pid    = TARGET_RESET;
    int          pkt_pos    = 0;
    logic [23:0] hdr_bytes  = '0;
    logic [3:0]  cc_next    = '0;
    bit          cc_known   = 1'b0;
    bit          seeking    = 1'b1;
    int          skip_left  = 0;
    t_mode       pmode      = MODE_HUNT;
    bit          af_len_due = 1'b0;
    bit          ptr_due    = 1'b0;
    bit          mark_due   = 1'b0;

    t_out_beat   expected_events[$];
    t_out_beat   want;
    int          mismatches   = 0;
    int          beats_sent   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_req  = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;

    function automatic void abort_packet();
        pmode      = MODE_DROP;
        seeking    = 1'b1;
        mark_due   = 1'b0;
        af_len_due = 1'b0;
        ptr_due    = 1'b0;
        skip_left  = 0;
    endfunction

    function automatic bit predict_extract(input t_in_beat beat, output t_out_beat ev);
        logic [7:0]  d;
        logic [7:0]  b1;
        logic [12:0] pid;
        logic [1:0]  afc;
        logic [3:0]  found;
        int          total;
        bit          hit;
        d   = beat.stream_byte;
        ev  = '0;
        hit = 1'b0;
        if (beat.seek_unit_start) begin
            seeking  = 1'b1;
            mark_due = 1'b0;
            if ((pmode == MODE_HEADER || pmode == MODE_BODY) && pkt_pos != 0) begin
                pmode      = MODE_DROP;
                af_len_due = 1'b0;
                ptr_due    = 1'b0;
                skip_left  = 0;
            end
        end
        if (pmode == MODE_HUNT) begin
            if (d == SYNC_BYTE) begin
                pmode     = MODE_HEADER;
                pkt_pos   = 1;
                hdr_bytes = '0;
            end
            return 1'b0;
        end
        case (pmode)
            MODE_HEADER: begin
                if (pkt_pos == 0) begin
                    if (d != SYNC_BYTE) begin
                        ev.event_kind = EV_SYNC_LOSS;
                        abort_packet();
                        pmode   = MODE_HUNT;
                        pkt_pos = 0;
                        return 1'b1;
                    end
                    hdr_bytes = '0;
                end else begin
                    hdr_bytes = {hdr_bytes[15:0], d};
                    if (pkt_pos == int'(HDR_LAST_POS)) begin
                        b1    = hdr_bytes[23:16];
                        pid   = {b1[4:0], hdr_bytes[15:8]};
                        afc   = d[5:4];
                        found = d[3:0];
                        if (b1[7]) begin
                            ev.event_kind = EV_TEI;
                            hit = 1'b1;
                            abort_packet();
                        end else if (d[7:6] != 2'b00) begin
                            ev.event_kind = EV_SCRAMBLED;
                            hit = 1'b1;
                            abort_packet();
                        end else if (pid == NULL_PID || pid != tgt_pid ||
                                     afc == AFC_ADAPT_ONLY) begin
                            pmode = MODE_DROP;
                        end else begin
                            if (!cc_known) cc_next = found;
                            if (cc_next != found) begin
                                ev.event_kind     = EV_CC_ERR;
                                ev.expected_count = cc_next;
                                ev.found_count    = found;
                                hit = 1'b1;
                            end
                            // resync to the counter in the header
                            cc_next  = found + 4'd1;
                            cc_known = 1'b1;
                            if (seeking && !b1[6]) begin
                                pmode = MODE_DROP;
                            end else begin
                                pmode      = MODE_BODY;
                                af_len_due = (afc == AFC_BOTH);
                                ptr_due    = b1[6] && seeking;
                                skip_left  = (!af_len_due && b1[6]) ? 1 : 0;
                            end
                        end
                    end
                end
            end
            MODE_BODY: begin
                if (af_len_due) begin
                    // adaptation length, plus the pointer byte on a unit start
                    total      = int'(d) + (hdr_bytes[22] ? 1 : 0);
                    af_len_due = 1'b0;
                    if (total > int'(MAX_ADAPT_LEN)) begin
                        ev.event_kind = EV_BAD_AF;
                        hit = 1'b1;
                        abort_packet();
                    end else begin
                        skip_left = total;
                    end
                end else if (skip_left > 0) begin
                    skip_left--;
                    if (skip_left == 0 && ptr_due) begin
                        ptr_due = 1'b0;
                        if (int'(d) > int'(PKT_LEN) - (pkt_pos + 1)) begin
                            ev.event_kind = EV_BAD_PTR;
                            hit = 1'b1;
                            abort_packet();
                        end else begin
                            skip_left = int'(d);
                            seeking   = 1'b0;
                            mark_due  = 1'b1;
                        end
                    end
                end else begin
                    ev.payload_byte = d;
                    ev.unit_start   = mark_due;
                    mark_due = 1'b0;
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        pkt_pos++;
        if (pkt_pos >= int'(PKT_LEN)) begin
            pkt_pos    = 0;
            pmode      = MODE_HEADER;
            af_len_due = 1'b0;
            ptr_due    = 1'b0;
            skip_left  = 0;
        end
        return hit;
    endfunction

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            i_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                if (mismatches < REPORT_CAP)
                    $display("%0t ns: result with nothing expected, got %p", $time, o_data);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                if (o_data !== want) begin
                    if (mismatches < REPORT_CAP) begin
                        if (o_data.event_kind !== want.event_kind)
                            $display("%0t ns: event_kind expected %0d got %0d",
                                     $time, want.event_kind, o_data.event_kind);
                        if (o_data.payload_byte !== want.payload_byte)
                            $display("%0t ns: payload_byte expected %h got %h",
                                     $time, want.payload_byte, o_data.payload_byte);
                        if (o_data.unit_start !== want.unit_start)
                            $display("%0t ns: unit_start expected %b got %b",
                                     $time, want.unit_start, o_data.unit_start);
                        if (o_data.expected_count !== want.expected_count)
                            $display("%0t ns: expected_count expected %0d got %0d",
                                     $time, want.expected_count, o_data.expected_count);
                        if (o_data.found_count !== want.found_count)
                            $display("%0t ns: found_count expected %0d got %0d",
                                     $time, want.found_count, o_data.found_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct = tx;
        rx_stall_pct <= rx;
    endtask

    task automatic send_beat(input logic [7:0] d, input bit seek);
        t_in_beat  beat;
        t_out_beat ev;
        beat.stream_byte     = d;
        beat.seek_unit_start = seek;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            i_data  <= 9'($urandom);
            @(posedge i_clk);
        end
        // hold valid and payload until the beat is taken
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        if (predict_extract(beat, ev)) expected_events.push_back(ev);
        beats_sent++;
    endtask

    task automatic send_packet(input ts_pkt_t p);
        logic [7:0] pkt [188];
        int         k;
        for (int i = 0; i < 188; i++) begin
            pkt[i] = 8'($urandom);
            // keep the hunt after a sync loss from locking inside this packet
            if (p.bad_sync && pkt[i] == SYNC_BYTE) pkt[i] = 8'h00;
        end
        pkt[0] = SYNC_BYTE;
        if (p.bad_sync) pkt[0] = 8'hB8;
        pkt[1] = {p.tei, p.pusi, 1'($urandom), p.pid[12:8]};
        pkt[2] = p.pid[7:0];
        pkt[3] = {p.scr, p.afc, p.cc};
        k = 4;
        if (p.afc[1]) begin
            pkt[4] = 8'(p.af_len);
            k = 5 + p.af_len;
        end
        if (p.pusi && k < int'(PKT_LEN)) pkt[k] = 8'(p.ptr);
        for (int i = 0; i < 188; i++) send_beat(pkt[i], i == p.seek_at);
    endtask

    function automatic ts_pkt_t target_pkt(input bit pusi);
        ts_pkt_t p;
        p.pid      = tgt_pid;
        p.tei      = 1'b0;
        p.pusi     = pusi;
        p.scr      = 2'b00;
        p.afc      = AFC_PAYLOAD;
        p.cc       = cc_next;
        p.af_len   = 0;
        p.ptr      = 0;
        p.seek_at  = -1;
        p.bad_sync = 1'b0;
        return p;
    endfunction

    task automatic wait_results();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TPID_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_target_reg();
        logic [31:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd !== {19'd0, tgt_pid}) begin
            $display("%0t ns: target_pid readback expected %h got %h",
                     $time, {19'd0, tgt_pid}, rd);
            mismatches++;
        end
    endtask

    task automatic cfg_target(input logic [12:0] v);
        logic [31:0] rd;
        wait_results();
        // junk in the unused upper bits
        apb_xfer(1'b1, {19'($urandom), v}, rd);
        tgt_pid = v;
        check_target_reg();
    endtask

    task automatic test_hunt_unit_start();
        ts_pkt_t p;
        set_idling(0, 0);
        check_target_reg();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h46, 1'b0);
        // reserved adaptation control carries payload only
        p = target_pkt(1'b1);
        p.afc = AFC_RESERVED;
        p.ptr = 2;
        send_packet(p);
    endtask

    task automatic test_pid_filter();
        ts_pkt_t p;
        set_idling(55, 0);
        p = target_pkt(1'b0);
        p.pid = tgt_pid ^ 13'h0001;
        send_packet(p);
    endtask

    task automatic test_continuity();
        ts_pkt_t p;
        set_idling(17, 17);
        p = target_pkt(1'b0);
        p.cc     = cc_next + 4'd3;
        p.afc    = AFC_BOTH;
        p.af_len = 10;
        send_packet(p);
    endtask

    task automatic test_adaptation();
        ts_pkt_t p;
        set_idling(0, 55);
        // adaptation length fits alone, but not with the pointer byte
        p = target_pkt(1'b1);
        p.afc    = AFC_BOTH;
        p.af_len = 183;
        send_packet(p);
    endtask

    task automatic test_header_errors();
        ts_pkt_t p;
        set_idling(55, 55);
        p = target_pkt(1'b0);
        p.tei = 1'b1;
        send_packet(p);
        // no sync where the next packet should start: hunt
        send_beat(8'hB8, 1'b0);
    endtask

    task automatic test_pointer();
        ts_pkt_t p;
        set_idling(17, 0);
        // pointer runs exactly to the packet end; mark carries over
        p = target_pkt(1'b1);
        p.afc    = AFC_BOTH;
        p.af_len = 5;
        p.ptr    = 177;
        send_packet(p);
    endtask

    task automatic test_target_extremes();
        set_idling(17, 17);
        cfg_target(NULL_PID);
        cfg_target(13'd0);
    endtask

    task automatic test_backpressure();
        ts_pkt_t p;
        set_idling(0, 0);
        rx_hold_req <= rx_hold_req + 1;
        // seek partway: drop the rest of the packet
        p = target_pkt(1'b0);
        p.seek_at = 120;
        send_packet(p);
        // pause the sender until every result is out
        wait_results();
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hunt_unit_start();
        test_pid_filter();
        test_continuity();
        test_adaptation();
        test_header_errors();
        test_pointer();
        test_target_extremes();
        test_backpressure();
        i_valid <= 1'b0;
        waited = 0;
        while (expected_events.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, expected_events.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
